// File: hw/rtl/pcx_rle_pixel_decoder_defines.svh
// ----------------------------------------------------------------------------
// PCX RLE pixel decoder assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_PIXEL_DECODER_DEFINES_SVH
`define PCX_RLE_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PCX_ASSERT_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PCX_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: hw/rtl/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// PCX RLE decoder package
// Widths, constants and the command and status types shared by the modules.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

    localparam int PIX_W      = 23;
    localparam int RUN_W      = 6;
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

    localparam logic [PIX_W-1:0] MAX_PIXELS = PIX_W'(4194304);
    localparam logic [7:0]       RUN_FLAG   = 8'hC0;
    localparam logic [7:0]       RUN_MASK   = 8'h3F;

    localparam logic REG_IMAGE_PIXELS = 1'b0;
    localparam logic REG_COMPRESSED   = 1'b1;

    // One decoded run: a value repeated count times, or an overrun report.
    typedef struct packed {
        logic [7:0]       value;
        logic [RUN_W-1:0] count;
        logic             done;
        logic             ovr;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// File: hw/rtl/pcxrle_front.sv
// ----------------------------------------------------------------------------
// PCX RLE front end
// Holds configuration and decode state, classifies each input byte and
// issues one run command for every byte that yields results.
// ----------------------------------------------------------------------------
module pcxrle_front
    import pcxrle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [PIX_W-1:0] cfg_data,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             new_image,
    output logic             cmd_wr,
    output cmd_t             cmd
);

    logic [PIX_W-1:0] image_pixels_reg;
    logic             compressed_reg;
    logic [PIX_W-1:0] pixels_written_reg, pixels_written_next;
    logic [RUN_W-1:0] run_remaining_reg, run_remaining_next;
    logic             count_pending_reg, count_pending_next;
    logic             stopped_reg, stopped_next;

    logic [PIX_W-1:0] limit;
    logic [PIX_W-1:0] pw_eff;
    logic [RUN_W-1:0] rr_eff;
    logic             cp_eff;
    logic             stop_eff;
    logic [RUN_W-1:0] count;
    logic             has_count;
    logic [PIX_W:0]   sum;

    assign limit = (image_pixels_reg > MAX_PIXELS) ? MAX_PIXELS : image_pixels_reg;

    always_comb
    begin
        pw_eff   = new_image ? '0 : pixels_written_reg;
        rr_eff   = new_image ? '0 : run_remaining_reg;
        cp_eff   = new_image ? 1'b0 : count_pending_reg;
        stop_eff = new_image ? 1'b0 : stopped_reg;

        pixels_written_next = pw_eff;
        run_remaining_next  = rr_eff;
        count_pending_next  = cp_eff;
        stopped_next        = stop_eff;

        count     = '0;
        has_count = 1'b0;
        cmd_wr    = 1'b0;
        cmd.value = data_byte;
        cmd.count = '0;
        cmd.done  = 1'b0;
        cmd.ovr   = 1'b0;

        if (!stop_eff && pw_eff < limit)
        begin
            if (!compressed_reg)
            begin
                count_pending_next = 1'b0;
                run_remaining_next = '0;
                count              = RUN_W'(1);
                has_count          = 1'b1;
            end
            else if (cp_eff)
            begin
                count_pending_next = 1'b0;
                run_remaining_next = '0;
                count              = rr_eff;
                has_count          = 1'b1;
            end
            else if ((data_byte & RUN_FLAG) == RUN_FLAG)
            begin
                run_remaining_next = RUN_W'(data_byte & RUN_MASK);
                count_pending_next = 1'b1;
            end
            else
            begin
                count     = RUN_W'(1);
                has_count = 1'b1;
            end
        end

        sum = {1'b0, pw_eff} + (PIX_W + 1)'(count);

        if (has_count && count != '0)
        begin
            cmd_wr = accept;
            if (sum > {1'b0, limit})
            begin
                // The whole run is dropped and one overrun report goes out.
                stopped_next = 1'b1;
                cmd.value    = '0;
                cmd.count    = RUN_W'(1);
                cmd.ovr      = 1'b1;
            end
            else
            begin
                pixels_written_next = sum[PIX_W-1:0];
                cmd.count           = count;
                cmd.done            = (sum == {1'b0, limit});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_pixels_reg   <= '0;
            compressed_reg     <= 1'b1;
            pixels_written_reg <= '0;
            run_remaining_reg  <= '0;
            count_pending_reg  <= 1'b0;
            stopped_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_PIXELS: image_pixels_reg <= cfg_data;
                    REG_COMPRESSED:   compressed_reg   <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (accept)
            begin
                pixels_written_reg <= pixels_written_next;
                run_remaining_reg  <= run_remaining_next;
                count_pending_reg  <= count_pending_next;
                stopped_reg        <= stopped_next;
            end
        end
    end

endmodule

// File: hw/rtl/pcxrle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// PCX RLE command queue
// Short queue of run commands between the front end and the expander.
// ----------------------------------------------------------------------------
module pcxrle_cmd_fifo
    import pcxrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  cmd_t       wr_cmd,
    input  logic       rd,
    output cmd_t       rd_cmd,
    output fifo_stat_t stat
);

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] fill_reg;
    logic                 do_wr;
    logic                 do_rd;

    assign stat.full  = (fill_reg == CMD_CNT_W'(CMD_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_cmd     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + CMD_CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - CMD_CNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/pcxrle_back.sv
// ----------------------------------------------------------------------------
// PCX RLE run expander
// Expands the head command into one result per cycle while results are
// taken, holding the oldest result in an output register until taken.
// ----------------------------------------------------------------------------
module pcxrle_back
    import pcxrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       cmd_empty,
    output logic       cmd_rd,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] pixel_value,
    output logic       pixel_valid,
    output logic       last_of_run,
    output logic       image_done,
    output logic       overrun
);

    logic             out_valid_reg;
    logic [RUN_W-1:0] emitted_reg;
    logic             load;
    logic             last;
    logic [7:0]       value_reg;
    logic             valid_reg;
    logic             last_reg;
    logic             done_reg;
    logic             ovr_reg;

    assign load   = !cmd_empty && (!out_valid_reg || pop);
    assign last   = (emitted_reg + RUN_W'(1)) == cmd.count;
    assign cmd_rd = load && last;

    assign empty       = !out_valid_reg;
    assign pixel_value = value_reg;
    assign pixel_valid = valid_reg;
    assign last_of_run = last_reg;
    assign image_done  = done_reg;
    assign overrun     = ovr_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= cmd.value;
            valid_reg <= !cmd.ovr;
            last_reg  <= last;
            done_reg  <= cmd.done && last;
            ovr_reg   <= cmd.ovr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            emitted_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                emitted_reg   <= last ? '0 : emitted_reg + RUN_W'(1);
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/pcx_rle_pixel_decoder.sv
// Path: an accepted byte writes its run command into the command queue, and
// the head command loads the result register once that is free or popped.
// Throughput: one input byte per cycle for literals and raw data; a run of n
// pixels is shown one result at a time from the single result register, and
// the input stalls once the four-entry command queue fills.
// Reset clears decode state, queue and output; compressed mode, image size zero.
// ----------------------------------------------------------------------------
// PCX RLE pixel decoder
// Decodes an 8-bit PCX image stream into pixel bytes, at most one per result.
// ----------------------------------------------------------------------------
`include "pcx_rle_pixel_decoder_defines.svh"

module pcx_rle_pixel_decoder
    import pcxrle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [PIX_W-1:0] cfg_data,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       data_byte,
    input  logic             new_image,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       pixel_value,
    output logic             pixel_valid,
    output logic             last_of_run,
    output logic             image_done,
    output logic             overrun
);

    logic       accept;
    logic       cmd_wr;
    cmd_t       wr_cmd;
    cmd_t       head_cmd;
    logic       cmd_rd;
    fifo_stat_t fifo_stat;

    assign full   = fifo_stat.full;
    assign accept = push && !fifo_stat.full;

    pcxrle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (data_byte),
        .new_image (new_image),
        .cmd_wr    (cmd_wr),
        .cmd       (wr_cmd)
    );

    pcxrle_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (cmd_wr),
        .wr_cmd (wr_cmd),
        .rd     (cmd_rd),
        .rd_cmd (head_cmd),
        .stat   (fifo_stat)
    );

    pcxrle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (head_cmd),
        .cmd_empty   (fifo_stat.empty),
        .cmd_rd      (cmd_rd),
        .pop         (pop),
        .empty       (empty),
        .pixel_value (pixel_value),
        .pixel_valid (pixel_valid),
        .last_of_run (last_of_run),
        .image_done  (image_done),
        .overrun     (overrun)
    );

    // A command must never be issued into a full queue.
    `PCX_ASSERT_IMPLY(a_no_write_when_full, fifo_stat.full, !cmd_wr, "command written while full")
    // The image can only complete on the final pixel of a run.
    `PCX_ASSERT_IMPLY(a_done_on_last, !empty && image_done, pixel_valid && last_of_run, "image_done off run end")
    // An overrun report carries no pixel and closes its byte.
    `PCX_ASSERT_IMPLY(a_overrun_form, !empty && overrun, !pixel_valid && last_of_run && !image_done, "bad overrun item")
    // With an empty queue and a taken result, nothing is left to show.
    `PCX_ASSERT_NEXT(a_drain, fifo_stat.empty && !cmd_wr && pop, empty, "result appeared from empty queue")

endmodule

// File: bench/pcx_pixel_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX pixel stream checker
// Watches the byte input, the result queue and the register port of the
// decoder, keeps its own copy of the decode state, and compares each popped
// pixel field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module pcx_pixel_stream_checker
    import pcxrle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [PIX_W-1:0] cfg_data,
    input  logic             push,
    input  logic             full,
    input  logic [7:0]       data_byte,
    input  logic             new_image,
    input  logic             pop,
    input  logic             empty,
    input  logic [7:0]       pixel_value,
    input  logic             pixel_valid,
    input  logic             last_of_run,
    input  logic             image_done,
    input  logic             overrun,
    output int               error_count,
    output int               pixels_outstanding,
    output logic             image_closed
);

    typedef struct packed {
        logic [7:0] value;
        logic       valid;
        logic       last;
        logic       done;
        logic       ovr;
    } pixel_t;

    pixel_t           pixel_q[$];
    logic [PIX_W-1:0] image_size;
    logic             rle_mode;
    logic [PIX_W-1:0] written;
    logic [RUN_W-1:0] run_left;
    logic             count_armed;
    logic             stopped;
    int               fails;

    function automatic logic [PIX_W-1:0] pixel_limit_now();
        return (image_size > MAX_PIXELS) ? MAX_PIXELS : image_size;
    endfunction

    // Applies one accepted byte to the decode state and queues the pixels
    // it produces.
    task automatic decode_byte(input logic [7:0] b, input logic start_image);
        logic [PIX_W-1:0] lim;
        int               run_len;
        pixel_t           px;
        if (start_image) begin
            written     = '0;
            run_left    = '0;
            count_armed = 1'b0;
            stopped     = 1'b0;
        end
        lim = pixel_limit_now();
        if (stopped || written >= lim)
            return;
        if (!rle_mode) begin
            count_armed = 1'b0;
            run_left    = '0;
            run_len     = 1;
        end else if (count_armed) begin
            run_len     = int'(run_left);
            count_armed = 1'b0;
            run_left    = '0;
        end else if ((b & RUN_FLAG) == RUN_FLAG) begin
            run_left    = RUN_W'(b & RUN_MASK);
            count_armed = 1'b1;
            return;
        end else begin
            run_len = 1;
        end
        if (run_len == 0)
            return;
        if (int'(written) + run_len > int'(lim)) begin
            // The whole run is dropped and a single overrun report is queued.
            stopped = 1'b1;
            px = '{value: 8'h00, valid: 1'b0, last: 1'b1, done: 1'b0, ovr: 1'b1};
            pixel_q.push_back(px);
            return;
        end
        for (int k = 0; k < run_len; k++)
        begin
            written = written + PIX_W'(1);
            px = '{value: b, valid: 1'b1, last: (k == run_len - 1),
                   done: (written == lim), ovr: 1'b0};
            pixel_q.push_back(px);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n) begin
            pixel_q.delete();
            image_size         = '0;
            rle_mode           = 1'b1;
            written            = '0;
            run_left           = '0;
            count_armed        = 1'b0;
            stopped            = 1'b0;
            fails              = 0;
            error_count        <= 0;
            pixels_outstanding <= 0;
            image_closed       <= 1'b1;
        end else begin
            if (pop && !empty) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected result: pixel_value %0h overrun %0b",
                           pixel_value, overrun);
                    fails++;
                end else begin
                    want = pixel_q.pop_front();
                    if (pixel_value !== want.value) begin
                        $error("pixel_value expected %0h actual %0h",
                               want.value, pixel_value);
                        fails++;
                    end
                    if (pixel_valid !== want.valid) begin
                        $error("pixel_valid expected %0b actual %0b",
                               want.valid, pixel_valid);
                        fails++;
                    end
                    if (last_of_run !== want.last) begin
                        $error("last_of_run expected %0b actual %0b",
                               want.last, last_of_run);
                        fails++;
                    end
                    if (image_done !== want.done) begin
                        $error("image_done expected %0b actual %0b",
                               want.done, image_done);
                        fails++;
                    end
                    if (overrun !== want.ovr) begin
                        $error("overrun expected %0b actual %0b",
                               want.ovr, overrun);
                        fails++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_IMAGE_PIXELS)
                    image_size = cfg_data;
                else
                    rle_mode = cfg_data[0];
            end
            if (push && !full)
                decode_byte(data_byte, new_image);
            error_count        <= fails;
            pixels_outstanding <= pixel_q.size();
            image_closed       <= stopped || (written >= pixel_limit_now());
        end
    end

endmodule

// File: bench/tb_pcx_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE pixel decoder testbench
// Drives directed and random PCX byte streams through the decoder under
// several register settings and idle patterns; the checker predicts and
// compares every pixel, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_pcx_rle_pixel_decoder;
    import pcxrle_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 250;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_we      = 1'b0;
    logic             cfg_index   = REG_IMAGE_PIXELS;
    logic [PIX_W-1:0] cfg_data    = '0;
    logic             push        = 1'b0;
    logic [7:0]       data_byte   = 8'h00;
    logic             new_image   = 1'b0;
    logic             pop         = 1'b0;
    logic             hold_req    = 1'b0;
    logic             full;
    logic             empty;
    logic [7:0]       pixel_value;
    logic             pixel_valid;
    logic             last_of_run;
    logic             image_done;
    logic             overrun;
    int               error_count;
    int               pixels_outstanding;
    logic             image_closed;

    int               send_idle_pct = 0;
    int               pop_stall_pct = 0;
    int               hold_left;
    logic             hold_taken;
    int               quiet_cycles;

    always #4 clk = ~clk;

    pcx_rle_pixel_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .new_image   (new_image),
        .pop         (pop),
        .empty       (empty),
        .pixel_value (pixel_value),
        .pixel_valid (pixel_valid),
        .last_of_run (last_of_run),
        .image_done  (image_done),
        .overrun     (overrun)
    );

    pcx_pixel_stream_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .push               (push),
        .full               (full),
        .data_byte          (data_byte),
        .new_image          (new_image),
        .pop                (pop),
        .empty              (empty),
        .pixel_value        (pixel_value),
        .pixel_valid        (pixel_valid),
        .last_of_run        (last_of_run),
        .image_done         (image_done),
        .overrun            (overrun),
        .error_count        (error_count),
        .pixels_outstanding (pixels_outstanding),
        .image_closed       (image_closed)
    );

    // Result side: random stalls, plus one long hold-off that lets the
    // command queue fill so the input side backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pop        <= 1'b0;
            hold_left  = 0;
            hold_taken = 1'b0;
        end else begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= pop_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Leaves push high after the accepting edge so back-to-back items need
    // only one assignment per step; callers that pause lower it themselves.
    task automatic send_item(input logic [7:0] b, input logic start_image);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        new_image <= start_image;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pixels_outstanding != 0)
            @(posedge clk);
        // A trailing count byte or ignored byte can still be in flight.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [PIX_W-1:0] pixels, input logic rle);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_PIXELS;
        cfg_data  <= pixels;
        @(posedge clk);
        cfg_index <= REG_COMPRESSED;
        cfg_data  <= PIX_W'(rle);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed PCX data: literal bytes and count/value pairs, with
    // a new image started soon after the current one is finished or stopped.
    task automatic random_stream(input int n_items);
        int         sent;
        int         kind;
        logic       start_image;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (image_closed)
                start_image = ($urandom_range(0, 99) < 85);
            else
                start_image = ($urandom_range(0, 99) < 3);
            if (!image_closed || start_image)
                sent++;
            if (kind < 45) begin
                b = 8'($urandom_range(0, 255));
                send_item({2'b11, b[5:0]}, start_image);
                send_item(8'($urandom_range(0, 255)), 1'b0);
                sent++;
            end else if (kind < 85) begin
                b = 8'($urandom_range(0, 255));
                if ((b & RUN_FLAG) == RUN_FLAG)
                    b[7] = 1'b0;
                send_item(b, start_image);
            end else begin
                send_item(8'($urandom_range(0, 255)), start_image);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration has an empty image, so nothing comes out.
        send_item(8'h3C, 1'b1);
        send_item(8'hC2, 1'b0);
        wait_drained();

        write_config(23'd40, 1'b1);
        send_item(8'h00, 1'b1);
        send_item(8'hBF, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'hC3, 1'b0);
        send_item(8'hFF, 1'b0);
        // A zero count swallows the following value byte.
        send_item(8'hC0, 1'b0);
        send_item(8'h55, 1'b0);
        // A run of 63 does not fit in the remaining pixels.
        send_item(8'hFF, 1'b0);
        send_item(8'hAA, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'hC1, 1'b1);
        send_item(8'hC0, 1'b0);
        // This run ends exactly on the last pixel of the image.
        send_item(8'hE7, 1'b0);
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        // A new image drops a count that was still waiting for its value.
        send_item(8'hC2, 1'b1);
        send_item(8'h05, 1'b1);
        send_item(8'hC4, 1'b0);
        wait_drained();

        // Raw mode discards the count armed above.
        write_config(23'd5, 1'b0);
        send_item(8'h22, 1'b0);
        send_item(8'hC5, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h11, 1'b0);
        wait_drained();

        write_config(23'd1, 1'b1);
        send_item(8'h80, 1'b1);
        send_item(8'h81, 1'b0);
        wait_drained();

        write_config(23'd0, 1'b1);
        send_item(8'h42, 1'b1);
        wait_drained();

        write_config(PIX_W'($urandom_range(100, 400)), 1'b1);
        random_stream(35);
        wait_drained();

        send_idle_pct = 49;
        write_config(PIX_W'($urandom_range(20, 60)), 1'b0);
        random_stream(35);
        wait_drained();

        send_idle_pct = 0;
        pop_stall_pct = 49;
        write_config(PIX_W'($urandom_range(8, 40)), 1'b1);
        random_stream(35);
        wait_drained();

        // Long runs against a held-off receiver fill the block up.
        pop_stall_pct = 0;
        write_config('1, 1'b1);
        hold_req <= 1'b1;
        send_item(8'hFF, 1'b1);
        send_item(8'($urandom_range(0, 255)), 1'b0);
        repeat (5) begin
            send_item(8'hFF, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        wait_drained();

        send_idle_pct = 35;
        pop_stall_pct = 35;
        random_stream(35);
        wait_drained();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/pcxrle_pkg.sv
hw/rtl/pcxrle_front.sv
hw/rtl/pcxrle_cmd_fifo.sv
hw/rtl/pcxrle_back.sv
hw/rtl/pcx_rle_pixel_decoder.sv
bench/pcx_pixel_stream_checker.sv
bench/tb_pcx_rle_pixel_decoder.sv
